// File: src/sobel_gradient_magnitude_angle_macros.svh
// assertion macros for the sobel gradient block
`ifndef SOBEL_GRADIENT_MAGNITUDE_ANGLE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_ANGLE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SGMA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// expression holds on every cycle out of reset
`define SGMA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define SGMA_ASSERT_IMPLY(label, ante, cons, msg)
`define SGMA_ASSERT_ALWAYS(label, expr, msg)
`endif

`endif

// File: src/sgma_pkg.sv
package sgma_pkg;

  // sizes
  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int PIX_W = 10;
  localparam int G_W = 13;
  localparam int XW = 28;
  localparam int ZW = 22;
  localparam int SQ_W = 25;
  localparam int ROOT_W = 13;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS = 13;

  // register indexes and reset values
  localparam logic CFG_IMAGE_WIDTH = 1'b0;
  localparam logic CFG_CHANNEL_COUNT = 1'b1;
  localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd640;
  localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd3;

  // angles in units of pi/2^20
  localparam logic signed [ZW-1:0] ANGLE_HALF_PI = 22'sd524288;
  localparam logic signed [ZW-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    22'sd262144, 22'sd154753, 22'sd81767, 22'sd41506, 22'sd20834, 22'sd10427,
    22'sd5215, 22'sd2608, 22'sd1304, 22'sd652, 22'sd326, 22'sd163,
    22'sd81, 22'sd41, 22'sd20, 22'sd10
  };

  // gradient pair entering the chain
  typedef struct packed {
    logic valid;
    logic last;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
  } kern_t;

  // state carried from cell to cell
  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SQ_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } cell_t;

endpackage

// File: src/sgma_prep.sv
module sgma_prep (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  sgma_pkg::kern_t kin,
  output sgma_pkg::cell_t cout
);

  localparam int XW = sgma_pkg::XW;
  localparam int SQ_W = sgma_pkg::SQ_W;

  sgma_pkg::cell_t nxt;
  logic signed [2*sgma_pkg::G_W-1:0] gxx;
  logic signed [2*sgma_pkg::G_W-1:0] gyy;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // squares for the root, quadrant fold for the rotation
  always_comb begin
    gxx = kin.gx * kin.gx;
    gyy = kin.gy * kin.gy;
    xs = XW'(kin.gx) <<< 12;
    ys = XW'(kin.gy) <<< 12;
    nxt.valid = kin.valid;
    nxt.last = kin.last;
    nxt.zero = (kin.gx == '0) && (kin.gy == '0);
    nxt.rem = SQ_W'(gxx) + SQ_W'(gyy);
    nxt.root = '0;
    if (kin.gx < 0) begin
      if (kin.gy >= 0) begin
        nxt.x = ys;
        nxt.y = -xs;
        nxt.z = sgma_pkg::ANGLE_HALF_PI;
      end else begin
        nxt.x = -ys;
        nxt.y = xs;
        nxt.z = -sgma_pkg::ANGLE_HALF_PI;
      end
    end else begin
      nxt.x = xs;
      nxt.y = ys;
      nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (advance) begin
      cout <= nxt;
    end
  end

endmodule

// File: src/sgma_cell.sv
module sgma_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  sgma_pkg::cell_t cin,
  output sgma_pkg::cell_t cout
);

  localparam int XW = sgma_pkg::XW;
  localparam int ROOT_W = sgma_pkg::ROOT_W;

  sgma_pkg::cell_t nxt;
  logic [ROOT_W-1:0] root_next;
  logic [sgma_pkg::SQ_W-1:0] rem_next;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // one root digit, only in the first cells
  if (STEP < sgma_pkg::SQRT_STEPS) begin : g_root
    localparam int B = sgma_pkg::SQRT_STEPS - 1 - STEP;
    logic [2*ROOT_W-1:0] delta;
    always_comb begin
      delta = ((2*ROOT_W)'(cin.root) << (B + 1)) | ((2*ROOT_W)'(1) << (2 * B));
      if ({1'b0, cin.rem} >= delta) begin
        rem_next = cin.rem - sgma_pkg::SQ_W'(delta);
        root_next = cin.root | (ROOT_W'(1) << B);
      end else begin
        rem_next = cin.rem;
        root_next = cin.root;
      end
    end
  end else begin : g_pass
    assign rem_next = cin.rem;
    assign root_next = cin.root;
  end

  // one rotation towards y = 0
  always_comb begin
    xs = cin.x >>> STEP;
    ys = cin.y >>> STEP;
    nxt = cin;
    nxt.rem = rem_next;
    nxt.root = root_next;
    if (cin.y < 0) begin
      nxt.x = cin.x - ys;
      nxt.y = cin.y + xs;
      nxt.z = cin.z - sgma_pkg::ATAN_TABLE[STEP];
    end else begin
      nxt.x = cin.x + ys;
      nxt.y = cin.y - xs;
      nxt.z = cin.z + sgma_pkg::ATAN_TABLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (advance) begin
      cout <= nxt;
    end
  end

endmodule

// File: src/sobel_gradient_magnitude_angle.sv
// channel  | direction | payload
// s_axis   | in        | tdata: chan_a, chan_b, chan_c; tuser: frame_start, pad_row
// m_axis   | out       | tdata: magnitude, angle; tlast: run_last
// cfg      | in        | image_width (index 0), channel_count (index 1)
// an item is accepted with a line store read, then updates the window and writes the
// line store back in ST_CALC, then gives each of its results from an emit state;
// no new item is taken before the sequencer is back in ST_IDLE. results pass the
// kernel register, squaring stage, 16 cordic cells that also carry the root digits
// and the output register. a stalled output holds the whole cell chain; reset clears
// control state and the window only, the line store needs no clearing.
`include "sobel_gradient_magnitude_angle_macros.svh"

module sobel_gradient_magnitude_angle #(
  parameter int MAX_WIDTH = sgma_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // chan_a, chan_b, chan_c
  input  logic [1:0] s_axis_tuser,   // frame_start, pad_row
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,  // magnitude, angle, zero fill
  output logic m_axis_tlast,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = sgma_pkg::PIX_W;
  localparam int GW = sgma_pkg::G_W;
  localparam int ZW = sgma_pkg::ZW;
  localparam int NC = sgma_pkg::CORDIC_STEPS;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT_A, ST_EMIT_B} state_t;

  state_t state;
  logic [11:0] image_width;
  logic [1:0] channel_count;
  logic [AW-1:0] column_pos;
  logic [1:0] row_seen;
  logic [AW-1:0] col_q;
  logic [PW-1:0] sum_q;
  logic pad_q;
  logic emit_b_q;
  logic [PW-1:0] rd_prev;
  logic [PW-1:0] rd_prev2;
  logic [PW-1:0] win [9];
  logic [PW-1:0] line0 [MAX_WIDTH];
  logic [PW-1:0] line1 [MAX_WIDTH];
  sgma_pkg::kern_t kreg;
  sgma_pkg::cell_t chain [NC+1];

  logic accept;
  logic advance;
  logic [13:0] width_wide;
  logic [WW-1:0] w_eff;
  logic [AW-1:0] w_last;
  logic [AW-1:0] cp_eff;
  logic [1:0] rs_eff;
  logic [AW-1:0] col_in;
  logic [PW-1:0] sum_in;
  logic [PW-1:0] prev;
  logic [PW-1:0] prev2;
  logic [PW-1:0] cur;
  logic col_is_last;
  logic [PW-1:0] l0, l1, l2, c0, c2, r0, r1, r2;
  logic signed [GW-1:0] gx;
  logic signed [GW-1:0] gy;
  logic signed [ZW-1:0] z_round;
  logic signed [13:0] angle_sat;
  logic [12:0] magnitude;
  logic signed [13:0] angle;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign advance = !m_axis_tvalid || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= sgma_pkg::IMAGE_WIDTH_RESET;
      channel_count <= sgma_pkg::CHANNEL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgma_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data;
        sgma_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // width in use, zero taken as one and clamped to the line store
  always_comb begin
    width_wide = {2'b00, image_width};
    if (width_wide == '0) begin
      w_eff = WW'(1);
    end else if (width_wide > 14'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_wide);
    end
    w_last = AW'(w_eff - WW'(1));
  end

  // column of the incoming item and its channel sum
  always_comb begin
    cp_eff = s_axis_tuser[0] ? '0 : column_pos;
    rs_eff = s_axis_tuser[0] ? 2'd0 : row_seen;
    col_in = (WW'(cp_eff) >= w_eff) ? w_last : cp_eff;
    sum_in = PW'(s_axis_tdata[7:0]);
    if (channel_count >= 2'd2) begin
      sum_in = sum_in + PW'(s_axis_tdata[15:8]);
    end
    if (channel_count == 2'd3) begin
      sum_in = sum_in + PW'(s_axis_tdata[23:16]);
    end
  end

  // values of the window's new column
  always_comb begin
    prev = rd_prev;
    prev2 = (row_seen < 2'd2) ? rd_prev : rd_prev2;
    cur = pad_q ? rd_prev : sum_q;
    col_is_last = (col_q == w_last);
  end

  // line store, read on accept and written back in the ST_CALC cycle that follows
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_prev <= line0[col_in];
      rd_prev2 <= line1[col_in];
    end
    if (state == ST_CALC) begin
      line0[col_q] <= cur;
      line1[col_q] <= prev;
    end
  end

  // sequencer, window and kernel register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      column_pos <= '0;
      row_seen <= 2'd0;
      emit_b_q <= 1'b0;
      kreg.valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      // a kernel result is loaded only from the emit states
      if (advance) begin
        kreg.valid <= (state == ST_EMIT_A) || (state == ST_EMIT_B);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser[0]) begin
              column_pos <= '0;
              row_seen <= 2'd0;
            end
            if (!(s_axis_tuser[1] && rs_eff == 2'd0)) begin
              col_q <= col_in;
              sum_q <= sum_in;
              pad_q <= s_axis_tuser[1];
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (col_q == '0) begin
            for (int k = 0; k < 3; k++) begin
              win[k*3] <= prev2;
              win[k*3+1] <= prev;
              win[k*3+2] <= cur;
            end
          end else begin
            for (int k = 0; k < 6; k++) begin
              win[k] <= win[k+3];
            end
            win[6] <= prev2;
            win[7] <= prev;
            win[8] <= cur;
          end
          emit_b_q <= (row_seen != 2'd0) && col_is_last;
          if (col_is_last) begin
            column_pos <= '0;
            if (row_seen < 2'd2) begin
              row_seen <= row_seen + 2'd1;
            end
          end else begin
            column_pos <= col_q + AW'(1);
          end
          if (row_seen != 2'd0 && col_q != '0) begin
            state <= ST_EMIT_A;
          end else if (row_seen != 2'd0 && col_is_last) begin
            state <= ST_EMIT_B;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT_A: begin
          if (advance) begin
            kreg.last <= !emit_b_q;
            kreg.gx <= gx;
            kreg.gy <= gy;
            state <= emit_b_q ? ST_EMIT_B : ST_IDLE;
          end
        end
        ST_EMIT_B: begin
          if (advance) begin
            kreg.last <= 1'b1;
            kreg.gx <= gx;
            kreg.gy <= gy;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sobel kernels; the right edge repeats the last column
  always_comb begin
    if (state == ST_EMIT_B) begin
      l0 = win[3]; l1 = win[4]; l2 = win[5];
      c0 = win[6]; c2 = win[8];
      r0 = win[6]; r1 = win[7]; r2 = win[8];
    end else begin
      l0 = win[0]; l1 = win[1]; l2 = win[2];
      c0 = win[3]; c2 = win[5];
      r0 = win[6]; r1 = win[7]; r2 = win[8];
    end
    gx = ($signed(GW'(r0)) + $signed(GW'({r1, 1'b0})) + $signed(GW'(r2)))
       - ($signed(GW'(l0)) + $signed(GW'({l1, 1'b0})) + $signed(GW'(l2)));
    gy = ($signed(GW'(l2)) + $signed(GW'({c2, 1'b0})) + $signed(GW'(r2)))
       - ($signed(GW'(l0)) + $signed(GW'({c0, 1'b0})) + $signed(GW'(r0)));
  end

  // squaring stage and the cell chain
  sgma_prep u_prep (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .kin(kreg),
    .cout(chain[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    sgma_cell #(.STEP(i)) u_cell (
      .clk(clk),
      .rst(rst),
      .advance(advance),
      .cin(chain[i]),
      .cout(chain[i+1])
    );
  end

  // angle rounding and clamp, zero for a zero gradient
  always_comb begin
    z_round = (chain[NC].z + ZW'(128)) >>> 8;
    if (chain[NC].zero) begin
      angle_sat = '0;
    end else if (z_round > ZW'(4096)) begin
      angle_sat = 14'sd4096;
    end else if (z_round < -ZW'(4096)) begin
      angle_sat = -14'sd4096;
    end else begin
      angle_sat = 14'(z_round);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= chain[NC].valid;
      m_axis_tlast <= chain[NC].last;
      magnitude <= chain[NC].root;
      angle <= angle_sat;
    end
  end

  assign m_axis_tdata = {5'b00000, angle, magnitude};

  `SGMA_ASSERT_IMPLY(a_col_in_range, state == ST_CALC, WW'(col_q) < w_eff, "column beyond width")
  `SGMA_ASSERT_IMPLY(a_second_at_edge, state == ST_EMIT_B, col_q == w_last, "edge result off edge")
  `SGMA_ASSERT_ALWAYS(a_rows_saturate, row_seen != 2'd3, "row count overflow")
  `SGMA_ASSERT_IMPLY(a_emit_needs_row, state == ST_EMIT_A || state == ST_EMIT_B, row_seen != 2'd0, "result before a full row")

endmodule

// File: verif/tb_sobel_gradient_magnitude_angle.sv
module tb_sobel_gradient_magnitude_angle;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = 2048;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [12:0] magnitude;
    logic [13:0] angle;
    logic run_last;
  } edge_result_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata;  // chan_a, chan_b, chan_c
  logic [1:0] s_axis_tuser;   // frame_start, pad_row
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;  // magnitude, angle, zero fill
  logic m_axis_tlast;
  logic cfg_we;
  logic cfg_index;
  logic [11:0] cfg_data;

  // predictor state
  logic [9:0] line_mem [2*LINE_MAX];
  logic [9:0] win [9];
  int unsigned col_pos;
  int unsigned rows_done;
  logic [11:0] width_reg;
  logic [1:0] chan_reg;
  edge_result_t pending[$];

  int errors;
  int items_sent;
  int src_idle_pct;
  int dst_idle_pct;
  int hold_count;

  sobel_gradient_magnitude_angle u_top (.*);

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // atan2 by vectoring cordic, units of pi/4096
  function automatic logic [13:0] grad_angle(input int gx, input int gy);
    longint atan_lut [16] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
                              1304, 652, 326, 163, 81, 41, 20, 10};
    longint x, y, z, nx, ny, t;
    if (gx == 0 && gy == 0) return '0;
    x = longint'(gx) * 4096;
    y = longint'(gy) * 4096;
    z = 0;
    if (gx < 0) begin
      t = x;
      if (gy >= 0) begin
        x = y; y = -t; z = 524288;
      end else begin
        x = -y; y = t; z = -524288;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
      y = ny;
    end
    z = (z + 128) >>> 8;
    if (z > 4096) z = 4096;
    if (z < -4096) z = -4096;
    return z[13:0];
  endfunction

  // floor of square root
  function automatic logic [12:0] grad_root(input int unsigned v);
    int unsigned r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[12:0];
  endfunction

  // kernels over columns starting at window indices lb, cb, rb
  function automatic void push_gradient(input int lb, input int cb, input int rb);
    int gx, gy;
    edge_result_t res;
    gx = (int'(win[rb]) + 2 * int'(win[rb+1]) + int'(win[rb+2]))
       - (int'(win[lb]) + 2 * int'(win[lb+1]) + int'(win[lb+2]));
    gy = (int'(win[lb+2]) + 2 * int'(win[cb+2]) + int'(win[rb+2]))
       - (int'(win[lb]) + 2 * int'(win[cb]) + int'(win[rb]));
    res.magnitude = grad_root(gx * gx + gy * gy);
    res.angle = grad_angle(gx, gy);
    res.run_last = 1'b0;
    pending.push_back(res);
  endfunction

  // expected results for one accepted pixel
  function automatic void predict_pixel(input logic [23:0] pix, input logic [1:0] flags);
    int unsigned w, col, n;
    logic [9:0] sum, prev, prev2, cur;
    edge_result_t tail;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (flags[0]) begin
      col_pos = 0;
      rows_done = 0;
    end
    if (flags[1] && rows_done == 0) return;
    col = (col_pos >= w) ? w - 1 : col_pos;
    sum = {2'b0, pix[7:0]};
    if (chan_reg >= 2) sum += pix[15:8];
    if (chan_reg >= 3) sum += pix[23:16];
    prev = line_mem[col];
    prev2 = (rows_done < 2) ? prev : line_mem[LINE_MAX + col];
    cur = flags[1] ? prev : sum;
    line_mem[LINE_MAX + col] = prev;
    line_mem[col] = cur;
    if (col == 0) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3] = prev2; win[k*3+1] = prev; win[k*3+2] = cur;
      end
    end else begin
      for (int k = 0; k < 6; k++) win[k] = win[k+3];
      win[6] = prev2; win[7] = prev; win[8] = cur;
    end
    n = 0;
    if (rows_done >= 1) begin
      if (col >= 1) begin
        push_gradient(0, 3, 6);
        n++;
      end
      if (col == w - 1) begin
        push_gradient(3, 6, 6);
        n++;
      end
      if (n > 0) begin
        tail = pending.pop_back();
        tail.run_last = 1'b1;
        pending.push_back(tail);
      end
    end
    if (col == w - 1) begin
      col_pos = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  // result checker and output back-pressure
  always @(posedge clk) begin
    edge_result_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual mag %0d ang %0d last %0b",
                 $time, m_axis_tdata[12:0], $signed(m_axis_tdata[26:13]), m_axis_tlast);
      end else begin
        exp_res = pending.pop_front();
        if (m_axis_tdata[12:0] !== exp_res.magnitude) begin
          errors++;
          $display("%0t: magnitude expected %0d actual %0d", $time, exp_res.magnitude,
                   m_axis_tdata[12:0]);
        end
        if (m_axis_tdata[26:13] !== exp_res.angle) begin
          errors++;
          $display("%0t: angle expected %0d actual %0d", $time, $signed(exp_res.angle),
                   $signed(m_axis_tdata[26:13]));
        end
        if (m_axis_tlast !== exp_res.run_last) begin
          errors++;
          $display("%0t: run_last expected %0b actual %0b", $time, exp_res.run_last,
                   m_axis_tlast);
        end
      end
    end
    if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // offer one pixel item and wait for it to be taken
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                            input bit fs, input bit pad);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, b, a};
    s_axis_tuser <= {pad, fs};
    do @(posedge clk); while (!s_axis_tready);
    predict_pixel({c, b, a}, {pad, fs});
    items_sent++;
  endtask

  // stop offering and let every expected result arrive
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sgma_pkg::CFG_IMAGE_WIDTH) width_reg = val;
    else chan_reg = (val[1:0] == 0) ? 2'd1 : val[1:0];
  endtask

  function automatic logic [7:0] rand_sample;
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // one frame: image rows then pad rows, optionally cut short
  task automatic send_frame(input int w, input int rows, input int pads, input bit ragged);
    int cut;
    cut = ragged ? $urandom_range(rows * w - 1) : rows * w;
    for (int i = 0; i < rows * w && i < cut; i++)
      send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0, 1'b0);
    if (cut < rows * w) return;
    for (int i = 0; i < pads * w; i++)
      send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b0, 1'b1);
  endtask

  task automatic test_directed;
    write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'd3);
    write_reg(sgma_pkg::CFG_CHANNEL_COUNT, 12'd3);
    // pad ahead of any full row is ignored
    send_pixel(8'd9, 8'd9, 8'd9, 1'b1, 1'b1);
    // step edge at full scale, then two pad rows
    for (int i = 0; i < 9; i++)
      send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, (i % 3 == 2) ? 8'd255 : 8'd0,
                 (i % 3 == 2) ? 8'd255 : 8'd0, i == 0, 1'b0);
    for (int i = 0; i < 6; i++) send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    // flat image gives zero gradient
    for (int i = 0; i < 6; i++) send_pixel(8'd77, 8'd1, 8'd200, i == 0, 1'b0);
    // channel count zero acts as one; width zero acts as one
    write_reg(sgma_pkg::CFG_CHANNEL_COUNT, 12'd0);
    write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'd0);
    send_frame(1, 3, 1, 1'b0);
    write_reg(sgma_pkg::CFG_CHANNEL_COUNT, 12'd2);
    write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'd1);
    send_frame(1, 3, 2, 1'b0);
    // oversized width acts as the line length limit; start of a first row only
    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'd4095);
    write_reg(sgma_pkg::CFG_CHANNEL_COUNT, 12'd1);
    for (int i = 0; i < 8; i++)
      send_pixel(rand_sample(), rand_sample(), rand_sample(), i == 0, 1'b0);
    write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'd5);
    write_reg(sgma_pkg::CFG_CHANNEL_COUNT, 12'd3);
  endtask

  task automatic test_random(input int src_pct, input int dst_pct, input int quota);
    int goal;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      if ($urandom_range(2) == 0) begin
        write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'($urandom_range(1, 8)));
        write_reg(sgma_pkg::CFG_CHANNEL_COUNT, 12'($urandom_range(1, 3)));
      end
      // stray flushes now and then
      if ($urandom_range(9) == 0)
        send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'($urandom_range(1)),
                   1'b1);
      send_frame((width_reg == 0) ? 1 : width_reg, $urandom_range(2, 5),
                 $urandom_range(0, 2), $urandom_range(7) == 0);
    end
  endtask

  // output held off long enough to back up the input
  task automatic test_backpressure;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_reg(sgma_pkg::CFG_IMAGE_WIDTH, 12'd6);
    hold_count = 400;
    send_frame(6, 12, 2, 1'b0);
    drain();
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_count = 0;
    width_reg = sgma_pkg::IMAGE_WIDTH_RESET;
    chan_reg = sgma_pkg::CHANNEL_COUNT_RESET;
    col_pos = 0;
    rows_done = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= sgma_pkg::CFG_IMAGE_WIDTH;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(30, 58, 200);
    test_random(58, 30, 200);
    test_random(0, 0, 200);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
